FILE: rtl/core/rtmt_pkg.sv
package rtmt_pkg;

    localparam logic signed [15:0] Q_41_0 = 16'sd10496;
    localparam logic signed [15:0] Q_35_5 = 16'sd9088;
    localparam logic signed [15:0] Q_36_5 = 16'sd9344;
    localparam logic signed [15:0] Q_25_0 = 16'sd6400;
    localparam logic signed [15:0] Q_35_0 = 16'sd8960;
    localparam logic [3:0] COEF_LO = 4'd2;
    localparam logic [3:0] COEF_HI = 4'd3;
    localparam logic [3:0] COEF_DEN = 4'd10;
    // x/10 as (x*ceil(2^21/10))>>21, exact for any 17-bit x
    localparam logic [17:0] DIV10_MUL = 18'd209716;
    localparam int DIV10_SHIFT = 21;

    localparam logic [2:0] CFG_SLOPE = 3'd0;
    localparam logic [2:0] CFG_SAMPLE_OFFSET = 3'd1;
    localparam logic [2:0] CFG_MIN_TEMP = 3'd2;
    localparam logic [2:0] CFG_MAX_TEMP = 3'd3;
    localparam logic [2:0] CFG_DRIFT_OFFSET = 3'd4;
    localparam logic [2:0] CFG_LEVEL_SPAN = 3'd5;

    localparam logic [1:0] BAND_LOW = 2'd0;
    localparam logic [1:0] BAND_MID = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;
    localparam logic [1:0] BAND_BELOW = 2'd3;

    typedef struct packed {
        logic signed [15:0] raw_sample;
        logic               last_sample;
    } t_in;

    typedef struct packed {
        logic signed [15:0] region_temp;
        logic [1:0]         band;
        logic               result_valid;
        logic signed [15:0] region_max;
        logic signed [15:0] region_min;
    } t_out;

    // classified sample as queued between front and back
    typedef struct packed {
        logic        neg;
        logic [15:0] mag;
        logic        last;
    } t_item;

    typedef struct packed {
        logic [15:0]        slope;
        logic signed [7:0]  sample_offset;
        logic signed [15:0] min_temp;
        logic signed [15:0] max_temp;
        logic signed [15:0] drift_offset;
        logic [14:0]        level_span;
    } t_cfg;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        logic signed [15:0] r;
        if (v > 32'sd32767) r = 16'sh7fff;
        else if (v < -32'sd32768) r = 16'sh8000;
        else r = v[15:0];
        return r;
    endfunction

endpackage

FILE: rtl/core/rtmt_front.sv
module rtmt_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  rtmt_pkg::t_in      i_in,
    output logic               o_q_valid,
    output rtmt_pkg::t_item    o_q_item,
    input  logic               i_q_pop
);

    rtmt_pkg::t_item r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push;
    rtmt_pkg::t_item item;

    always_comb begin
        item.neg  = i_in.raw_sample[15];
        item.mag  = i_in.raw_sample[15] ? 16'(-i_in.raw_sample) : 16'(i_in.raw_sample);
        item.last = i_in.last_sample;
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

endmodule

FILE: rtl/core/rtmt_div.sv
module rtmt_div #(
    parameter int NW = 40,
    parameter int DW = 17
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CW = $clog2(NW + 1);

    logic          r_busy, r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem, r_den;
    logic [DW:0]   t, diff;
    logic          ge;

    // restoring, one quotient bit a cycle
    always_comb begin
        t    = {r_rem, r_quo[NW-1]};
        diff = t - {1'b0, r_den};
        ge   = (t >= {1'b0, r_den});
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? diff[DW-1:0] : t[DW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/core/rtmt_back.sv
module rtmt_back #(
    parameter int MAX_REGION_SAMPLES = 65536
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rtmt_pkg::t_cfg  i_cfg,
    input  logic            i_q_valid,
    input  rtmt_pkg::t_item i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output rtmt_pkg::t_out  o_out
);

    localparam int CNT_W = $clog2(MAX_REGION_SAMPLES + 1);
    localparam int SUM_W = CNT_W + 17;
    localparam int NW    = (SUM_W > 25) ? SUM_W : 25;
    localparam int DW    = (CNT_W > 16) ? CNT_W : 16;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_SDIV = 8'b0000_0010,
        ST_ACC  = 8'b0000_0100,
        ST_TRIM = 8'b0000_1000,
        ST_MDIV = 8'b0001_0000,
        ST_CORR = 8'b0010_0000,
        ST_CDIV = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    logic                    r_last, r_neg;
    logic signed [15:0]      r_value, r_mean, r_max, r_min, r_temp;
    logic signed [SUM_W-1:0] r_sum, r_mxs, r_mns;
    logic [CNT_W-1:0]        r_cnt, r_mxc, r_mnc;
    logic [1:0]              r_band;
    logic                    r_rvalid;
    logic                    r_out_valid;
    rtmt_pkg::t_out          r_out;
    logic [16:0]             r_prod;

    logic          div_start, div_done;
    logic [NW-1:0] div_num, div_quo;
    logic [DW-1:0] div_den;

    rtmt_div #(.NW(NW), .DW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    logic signed [25:0]      sq, sv;
    logic signed [15:0]      scaled;
    logic                    inband;
    logic signed [SUM_W:0]   tsum;
    logic signed [CNT_W:0]   tcnt;
    logic                    ext_ne;
    logic signed [16:0]      qm;
    logic signed [19:0]      m20, lo20, ls20, lsh20, t1, t2;
    logic [16:0]             prod;
    logic [34:0]             rec;
    logic [3:0]              coef;
    logic                    out_free;

    always_comb begin
        sq = r_neg ? -$signed({1'b0, div_quo[24:0]}) : $signed({1'b0, div_quo[24:0]});
        sv = sq + 26'(i_cfg.sample_offset * 256);
        scaled = rtmt_pkg::sat16(32'(sv));
        inband = (r_value >= i_cfg.min_temp) && (r_value <= i_cfg.max_temp)
                 && (r_cnt < CNT_W'(MAX_REGION_SAMPLES));

        ext_ne = (r_max != r_min);
        tsum = (SUM_W+1)'(r_sum) - (SUM_W+1)'(r_mxs) - (ext_ne ? (SUM_W+1)'(r_mns) : '0);
        tcnt = $signed({1'b0, r_cnt}) - $signed({1'b0, r_mxc})
               - (ext_ne ? $signed({1'b0, r_mnc}) : '0);

        qm = $signed({1'b0, div_quo[15:0]});
        if (div_quo[16]) qm = 17'sh10000;

        m20   = 20'(r_mean);
        lo20  = 20'(i_cfg.min_temp);
        ls20  = lo20 + 20'($signed({1'b0, i_cfg.level_span}));
        lsh20 = ls20 + 20'sd256;
        coef  = (i_cfg.min_temp >= rtmt_pkg::Q_25_0 && i_cfg.min_temp < rtmt_pkg::Q_35_0)
                ? rtmt_pkg::COEF_HI : rtmt_pkg::COEF_LO;
        prod  = 17'((m20 - lo20) * $signed({1'b0, coef}));
        rec   = r_prod * rtmt_pkg::DIV10_MUL;
        t1    = m20 - ls20 + 20'(rtmt_pkg::Q_36_5) + 20'(i_cfg.drift_offset);
        t2    = m20 + 20'($signed({1'b0, i_cfg.level_span})) + 20'(i_cfg.drift_offset);
        out_free = !r_out_valid || i_ready;
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_num   = NW'(i_q_item.mag) << 8;
        div_den   = (i_cfg.slope == 16'd0) ? DW'(1) : DW'(i_cfg.slope);
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop   = 1'b1;
                    div_start = 1'b1;
                    n_state   = ST_SDIV;
                end
            end
            ST_SDIV: if (div_done) n_state = ST_ACC;
            ST_ACC: n_state = r_last ? ST_TRIM : ST_IDLE;
            ST_TRIM: begin
                div_num = tsum[SUM_W] ? NW'(-tsum) : NW'(tsum);
                div_den = DW'(tcnt[CNT_W-1:0]);
                if (tcnt > 0) begin
                    div_start = 1'b1;
                    n_state   = ST_MDIV;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_MDIV: if (div_done) n_state = ST_CORR;
            ST_CORR: begin
                if (m20 >= lo20 && m20 < ls20) n_state = ST_CDIV;
                else n_state = ST_OUT;
            end
            ST_CDIV: n_state = ST_OUT;
            ST_OUT: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum <= '0;
            r_cnt <= '0;
            r_max <= '0;
            r_min <= rtmt_pkg::Q_41_0;
            r_mxs <= '0;
            r_mxc <= '0;
            r_mns <= '0;
            r_mnc <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == ST_OUT && out_free) || (r_out_valid && !i_ready);
            if (r_state == ST_ACC && inband) begin
                r_sum <= r_sum + SUM_W'(r_value);
                r_cnt <= r_cnt + 1'b1;
                if (r_value > r_max) begin
                    r_max <= r_value;
                    r_mxs <= SUM_W'(r_value);
                    r_mxc <= CNT_W'(1);
                end else if (r_value == r_max) begin
                    r_mxs <= r_mxs + SUM_W'(r_value);
                    r_mxc <= r_mxc + 1'b1;
                end
                if (r_value < r_min) begin
                    r_min <= r_value;
                    r_mns <= SUM_W'(r_value);
                    r_mnc <= CNT_W'(1);
                end else if (r_value == r_min) begin
                    r_mns <= r_mns + SUM_W'(r_value);
                    r_mnc <= r_mnc + 1'b1;
                end
            end
            if (r_state == ST_OUT && out_free) begin
                r_sum <= '0;
                r_cnt <= '0;
                r_max <= '0;
                r_min <= rtmt_pkg::Q_41_0;
                r_mxs <= '0;
                r_mxc <= '0;
                r_mns <= '0;
                r_mnc <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_q_valid) begin
            r_neg  <= i_q_item.neg;
            r_last <= i_q_item.last;
        end
        if (r_state == ST_SDIV && div_done) r_value <= scaled;
        if (r_state == ST_TRIM) begin
            r_mean   <= '0;
            r_neg    <= tsum[SUM_W];
            r_rvalid <= (tcnt > 0);
            r_temp   <= '0;
            r_band   <= rtmt_pkg::BAND_LOW;
        end
        if (r_state == ST_MDIV && div_done) r_mean <= r_neg ? 16'(-qm) : 16'(qm);
        if (r_state == ST_CORR) begin
            r_prod <= prod;
            if (m20 >= lo20 && m20 < ls20) begin
                r_band <= rtmt_pkg::BAND_LOW;
            end else if (m20 >= ls20 && m20 < lsh20) begin
                r_band <= rtmt_pkg::BAND_MID;
                r_temp <= rtmt_pkg::sat16(32'(t1));
            end else if (m20 >= lsh20) begin
                r_band <= rtmt_pkg::BAND_HIGH;
                r_temp <= rtmt_pkg::sat16(32'(t2));
            end else begin
                r_band <= rtmt_pkg::BAND_BELOW;
                r_temp <= r_mean;
            end
        end
        // low band: scaled offset divided by ten through the reciprocal
        if (r_state == ST_CDIV)
            r_temp <= 16'(rec[34:rtmt_pkg::DIV10_SHIFT]) + rtmt_pkg::Q_35_5;
        if (r_state == ST_OUT && out_free) begin
            r_out.region_temp  <= r_temp;
            r_out.band         <= r_band;
            r_out.result_valid <= r_rvalid;
            r_out.region_max   <= r_max;
            r_out.region_min   <= r_min;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule

FILE: rtl/core/region_trimmed_mean_temperature.sv
// Trimmed-mean region temperature. Samples of one region arrive one word at a
// time, the final one flagged by last_sample; only that word produces a result.
// A two-word input queue lets the source run ahead of the processing engine.
// Each sample is scaled by a shared bit-serial divider (one quotient bit per
// cycle, 34 steps with the default MAX_REGION_SAMPLES); the last sample then
// adds the mean division and correction (a reciprocal step in the low band,
// no division when nothing survives trimming) and any output register wait.
// The result waits in an output register while the next region is processed.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
module region_trimmed_mean_temperature #(
    parameter int MAX_REGION_SAMPLES = 65536
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rtmt_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_ready,
    output rtmt_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic [2:0]     i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);

    rtmt_pkg::t_cfg  r_cfg;
    logic            q_valid, q_pop;
    rtmt_pkg::t_item q_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slope         <= 16'd100;
            r_cfg.sample_offset <= 8'sd0;
            r_cfg.min_temp      <= 16'sd7680;
            r_cfg.max_temp      <= 16'sd10752;
            r_cfg.drift_offset  <= 16'sd0;
            r_cfg.level_span    <= 15'd512;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rtmt_pkg::CFG_SLOPE:         r_cfg.slope <= i_cfg_data;
                rtmt_pkg::CFG_SAMPLE_OFFSET: r_cfg.sample_offset <= i_cfg_data[7:0];
                rtmt_pkg::CFG_MIN_TEMP:      r_cfg.min_temp <= i_cfg_data;
                rtmt_pkg::CFG_MAX_TEMP:      r_cfg.max_temp <= i_cfg_data;
                rtmt_pkg::CFG_DRIFT_OFFSET:  r_cfg.drift_offset <= i_cfg_data;
                rtmt_pkg::CFG_LEVEL_SPAN:    r_cfg.level_span <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    rtmt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    rtmt_back #(.MAX_REGION_SAMPLES(MAX_REGION_SAMPLES)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/core/rtmt_checker.sv
module rtmt_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_valid,
    input logic           i_ready,
    input rtmt_pkg::t_out o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result word dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_out))
        else $error("result word changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out.result_valid |->
            o_out.region_temp == 16'sd0 && o_out.band == rtmt_pkg::BAND_LOW)
        else $error("empty region result not cleared");

    a_extremes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.result_valid |-> o_out.region_max != o_out.region_min)
        else $error("valid mean with equal extremes");

    a_low_band: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.result_valid && o_out.band == rtmt_pkg::BAND_LOW |->
            o_out.region_temp >= rtmt_pkg::Q_35_5)
        else $error("low band result below base");

endmodule

bind region_trimmed_mean_temperature rtmt_checker u_rtmt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_out   (o_out)
);
